[design/eegpp_pkg.sv]
// Package for the headset packet parser: parser state, result types and byte codes.
// Used by eegpp_step and eeg_headset_packet_parser_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package eegpp_pkg;

    // Framing and row codes
    localparam logic [7:0] SYNC_BYTE       = 8'hAA;
    localparam logic [7:0] EXT_BYTE        = 8'h55;
    localparam logic [7:0] RAW_CODE        = 8'h80;
    localparam logic [7:0] QUALITY_CODE    = 8'h02;
    localparam logic [7:0] ATTENTION_CODE  = 8'h04;
    localparam logic [7:0] MEDITATION_CODE = 8'h05;

    // Result kinds
    localparam logic [1:0] KIND_QUALITY    = 2'd0;
    localparam logic [1:0] KIND_ATTENTION  = 2'd1;
    localparam logic [1:0] KIND_MEDITATION = 2'd2;
    localparam logic [1:0] KIND_RAW        = 2'd3;

    typedef enum logic [2:0] {
        PH_SYNC1  = 3'd0,
        PH_SYNC2  = 3'd1,
        PH_LEN    = 3'd2,
        PH_ROW    = 3'd3,
        PH_ROWLEN = 3'd4,
        PH_VALUE  = 3'd5
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  payload_left;
        logic [7:0]  row_code;
        logic [7:0]  value_left;
        logic [1:0]  value_position;
        logic [7:0]  sample_high;
    } parse_state_t;

    typedef struct packed {
        logic               emit;
        logic [1:0]         kind;
        logic signed [15:0] value;
    } result_t;

endpackage

`default_nettype wire

[design/eegpp_step.sv]
// Combinational next-state and result logic of the packet parser for one byte.
// Depends on eegpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module eegpp_step
(
    input  wire eegpp_pkg::parse_state_t cur,
    input  wire logic [7:0]              rx_byte,
    output eegpp_pkg::parse_state_t      nxt,
    output eegpp_pkg::result_t           res
);

    logic in_payload;
    logic fits;
    logic simple_code;

    assign fits        = (cur.value_left <= cur.payload_left);
    assign simple_code = (cur.row_code == eegpp_pkg::QUALITY_CODE)
                      || (cur.row_code == eegpp_pkg::ATTENTION_CODE)
                      || (cur.row_code == eegpp_pkg::MEDITATION_CODE);

    always_comb
    begin
        nxt        = cur;
        res        = '0;
        in_payload = 1'b0;

        case (cur.phase)
            eegpp_pkg::PH_SYNC1:
            begin
                if (rx_byte == eegpp_pkg::SYNC_BYTE)
                begin
                    nxt.phase = eegpp_pkg::PH_SYNC2;
                end
            end
            eegpp_pkg::PH_SYNC2:
            begin
                nxt.phase = (rx_byte == eegpp_pkg::SYNC_BYTE) ? eegpp_pkg::PH_LEN
                                                              : eegpp_pkg::PH_SYNC1;
            end
            eegpp_pkg::PH_LEN:
            begin
                // length must be non-zero and below the sync byte
                if (rx_byte >= eegpp_pkg::SYNC_BYTE || rx_byte == 8'd0)
                begin
                    nxt.phase = eegpp_pkg::PH_SYNC1;
                end
                else
                begin
                    nxt.payload_left = rx_byte;
                    nxt.phase        = eegpp_pkg::PH_ROW;
                end
            end
            eegpp_pkg::PH_ROW:
            begin
                in_payload = 1'b1;
                // extended-code bytes are skipped
                if (rx_byte != eegpp_pkg::EXT_BYTE)
                begin
                    nxt.row_code       = rx_byte;
                    nxt.value_position = 2'd0;
                    if (rx_byte[7])
                    begin
                        nxt.phase = eegpp_pkg::PH_ROWLEN;
                    end
                    else
                    begin
                        nxt.value_left = 8'd1;
                        nxt.phase      = eegpp_pkg::PH_VALUE;
                    end
                end
            end
            eegpp_pkg::PH_ROWLEN:
            begin
                in_payload         = 1'b1;
                nxt.value_left     = rx_byte;
                nxt.value_position = 2'd0;
                nxt.phase = (rx_byte != 8'd0) ? eegpp_pkg::PH_VALUE : eegpp_pkg::PH_ROW;
            end
            eegpp_pkg::PH_VALUE:
            begin
                in_payload = 1'b1;
                if (cur.value_position == 2'd0 && simple_code)
                begin
                    // first value byte of a single-byte code
                    if (fits)
                    begin
                        res.emit  = 1'b1;
                        res.kind  = (cur.row_code == eegpp_pkg::QUALITY_CODE)
                                  ? eegpp_pkg::KIND_QUALITY
                                  : (cur.row_code == eegpp_pkg::ATTENTION_CODE)
                                  ? eegpp_pkg::KIND_ATTENTION
                                  : eegpp_pkg::KIND_MEDITATION;
                        res.value = {8'h00, rx_byte};
                    end
                end
                else if (cur.row_code == eegpp_pkg::RAW_CODE)
                begin
                    // raw sample: high byte first
                    if (cur.value_position == 2'd0)
                    begin
                        nxt.sample_high = rx_byte;
                    end
                    else if (cur.value_position == 2'd1 && fits)
                    begin
                        res.emit  = 1'b1;
                        res.kind  = eegpp_pkg::KIND_RAW;
                        res.value = {cur.sample_high, rx_byte};
                    end
                end
                if (cur.value_position != 2'd3)
                begin
                    nxt.value_position = cur.value_position + 2'd1;
                end
                if (cur.value_left != 8'd0)
                begin
                    nxt.value_left = cur.value_left - 8'd1;
                end
                if (nxt.value_left == 8'd0)
                begin
                    nxt.phase = eegpp_pkg::PH_ROW;
                end
            end
            default:
            begin
                nxt.phase = eegpp_pkg::PH_SYNC1;
            end
        endcase

        // payload count; its end always returns to hunting
        if (in_payload)
        begin
            if (cur.payload_left != 8'd0)
            begin
                nxt.payload_left = cur.payload_left - 8'd1;
            end
            if (nxt.payload_left == 8'd0)
            begin
                nxt.phase = eegpp_pkg::PH_SYNC1;
            end
        end
    end

endmodule

`default_nettype wire

[design/eeg_headset_packet_parser_core.sv]
// Top level of the headset serial packet parser: input register, parser state, result register.
// Depends on eegpp_pkg and eegpp_step.
`timescale 1ns / 1ps
`default_nettype none

// Takes one received serial byte per transfer and gives a result transfer for each
// signal quality, attention and meditation value and each 16-bit raw sample found in a
// framed packet. A byte is taken every clock while the input does not stall; a result
// passes from the input register, where the parser state is updated, to the result
// register. The input only stalls when the result register is held by a stalled
// output and the byte waiting in the input register would produce another result.
// The checksum byte is not verified and extended-code levels are ignored.
module eeg_headset_packet_parser_core
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_stall,
    input  wire logic [7:0]         rx_byte,
    output      logic               out_valid,
    input  wire logic               out_stall,
    output      logic [1:0]         value_kind,
    output      logic signed [15:0] value
);

    logic                    in_full_reg;
    logic                    in_full_next;
    logic [7:0]              byte_reg;
    eegpp_pkg::parse_state_t state_reg;
    eegpp_pkg::parse_state_t state_next;
    eegpp_pkg::result_t      step_res;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [1:0]              kind_reg;
    logic signed [15:0]      value_reg;
    logic                    step_go;
    logic                    in_take;

    // Parser logic for the byte held in the input register
    eegpp_step u_step
    (
        .cur     (state_reg),
        .rx_byte (byte_reg),
        .nxt     (state_next),
        .res     (step_res)
    );

    // Byte proceeds unless it has a result and the result register cannot take it
    assign step_go  = in_full_reg && (!step_res.emit || !out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !step_go;
    assign in_take  = in_valid && !in_stall;

    assign in_full_next   = in_take || (in_full_reg && !step_go);
    assign out_valid_next = (out_valid_reg && out_stall) || (step_go && step_res.emit);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: eegpp_pkg::PH_SYNC1, default: '0};
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
            if (step_go)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= rx_byte;
        end
        if (step_go && step_res.emit)
        begin
            kind_reg  <= step_res.kind;
            value_reg <= step_res.value;
        end
    end

    assign out_valid  = out_valid_reg;
    assign value_kind = kind_reg;
    assign value      = value_reg;

`ifndef SYNTHESIS
    // outside a payload the remaining count is always zero, inside never
    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.payload_left == 8'd0) == (state_reg.phase == eegpp_pkg::PH_SYNC1
            || state_reg.phase == eegpp_pkg::PH_SYNC2 || state_reg.phase == eegpp_pkg::PH_LEN))
        else $error("payload count out of step with frame phase");

    // framing bytes never produce a result
    a_no_emit_framing: assert property (@(posedge clk) disable iff (!rst_n)
        (in_full_reg && (state_reg.phase == eegpp_pkg::PH_SYNC1
            || state_reg.phase == eegpp_pkg::PH_SYNC2 || state_reg.phase == eegpp_pkg::PH_LEN))
        |-> !step_res.emit)
        else $error("result produced outside a payload");

    // a held result blocks a second result byte
    a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && in_full_reg && step_res.emit) |=> $stable(state_reg))
        else $error("parser advanced while its result could not be stored");

    // byte-valued kinds are zero-extended
    a_byte_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != eegpp_pkg::KIND_RAW) |-> (value_reg[15:8] == 8'h00))
        else $error("non-raw value wider than a byte");
`endif

endmodule

`default_nettype wire

[tb/eegpp_reading_checker.sv]
// Reading checker for the headset packet parser: tracks the framing state from accepted
// bytes, predicts each reading and compares it with the result transfers.
// Depends on eegpp_pkg.
`timescale 1ns / 1ps

module eegpp_reading_checker
    import eegpp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [1:0]         value_kind,
    input  wire logic signed [15:0] value,
    output int                      mismatches,
    output int                      readings_due,
    output int                      bytes_taken,
    output int                      readings_checked
);

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] value;
    } reading_t;

    // Framing state as the parser should hold it
    phase_t     phase;
    logic [7:0] payload_left;
    logic [7:0] row_code;
    logic [7:0] value_left;
    logic [1:0] value_pos;
    logic [7:0] sample_high;

    reading_t   due_readings [$];

    initial
    begin
        mismatches       = 0;
        readings_due     = 0;
        bytes_taken      = 0;
        readings_checked = 0;
    end

    function automatic void note_reading(input logic [1:0] kind, input logic [15:0] v);
        reading_t r;
        r.kind  = kind;
        r.value = v;
        due_readings.push_back(r);
    endfunction

    // Advance the framing state by one byte and queue any reading it yields
    task automatic track_frame_byte(input logic [7:0] b);
        logic fits;
        logic in_payload;
        logic [1:0] kind;
        in_payload = 1'b1;
        case (phase)
            PH_SYNC1:
            begin
                if (b == SYNC_BYTE)
                    phase = PH_SYNC2;
                in_payload = 1'b0;
            end
            PH_SYNC2:
            begin
                phase = (b == SYNC_BYTE) ? PH_LEN : PH_SYNC1;
                in_payload = 1'b0;
            end
            PH_LEN:
            begin
                if (b >= SYNC_BYTE || b == 8'h00)
                    phase = PH_SYNC1;
                else
                begin
                    payload_left = b;
                    phase = PH_ROW;
                end
                in_payload = 1'b0;
            end
            PH_ROW:
            begin
                // extended-code bytes are passed over
                if (b != EXT_BYTE)
                begin
                    row_code  = b;
                    value_pos = 2'd0;
                    if (b[7])
                        phase = PH_ROWLEN;
                    else
                    begin
                        value_left = 8'd1;
                        phase = PH_VALUE;
                    end
                end
            end
            PH_ROWLEN:
            begin
                value_left = b;
                value_pos  = 2'd0;
                phase = (b != 8'h00) ? PH_VALUE : PH_ROW;
            end
            PH_VALUE:
            begin
                fits = (value_left <= payload_left);
                if (value_pos == 2'd0 && (row_code == QUALITY_CODE ||
                    row_code == ATTENTION_CODE || row_code == MEDITATION_CODE))
                begin
                    kind = (row_code == QUALITY_CODE)   ? KIND_QUALITY :
                           (row_code == ATTENTION_CODE) ? KIND_ATTENTION : KIND_MEDITATION;
                    if (fits)
                        note_reading(kind, {8'h00, b});
                end
                else if (row_code == RAW_CODE)
                begin
                    if (value_pos == 2'd0)
                        sample_high = b;
                    else if (value_pos == 2'd1 && fits)
                        note_reading(KIND_RAW, {sample_high, b});
                end
                if (value_pos < 2'd3)
                    value_pos = value_pos + 2'd1;
                if (value_left > 8'd0)
                    value_left = value_left - 8'd1;
                if (value_left == 8'd0)
                    phase = PH_ROW;
            end
            default:
            begin
                phase = PH_SYNC1;
                in_payload = 1'b0;
            end
        endcase
        // payload end always drops back to hunting
        if (in_payload)
        begin
            if (payload_left > 8'd0)
                payload_left = payload_left - 8'd1;
            if (payload_left == 8'd0)
                phase = PH_SYNC1;
        end
    endtask

    // Watch both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            phase        = PH_SYNC1;
            payload_left = 8'h00;
            row_code     = 8'h00;
            value_left   = 8'h00;
            value_pos    = 2'd0;
            sample_high  = 8'h00;
            due_readings.delete();
            readings_due = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                track_frame_byte(rx_byte);
                bytes_taken++;
            end
            if (out_valid && !out_stall)
            begin
                if (due_readings.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: unexpected reading, expected none, got kind %0d value %0d",
                             $time, value_kind, value);
                end
                else
                begin
                    want = due_readings.pop_front();
                    readings_checked++;
                    if (value_kind !== want.kind)
                    begin
                        mismatches++;
                        $display("%0t ns: kind mismatch, expected %0d, got %0d",
                                 $time, want.kind, value_kind);
                    end
                    if (value !== want.value)
                    begin
                        mismatches++;
                        $display("%0t ns: value mismatch, expected %0d, got %0d",
                                 $time, want.value, value);
                    end
                end
            end
            readings_due = due_readings.size();
        end
    end

endmodule

[tb/eeg_headset_packet_parser_core_tb.sv]
// Testbench top for the headset packet parser: clock, reset, byte stream and output stalls.
// Depends on eegpp_pkg, eeg_headset_packet_parser_core and eegpp_reading_checker.
`timescale 1ns / 1ps

module eeg_headset_packet_parser_core_tb;
    import eegpp_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int TOTAL_BYTES  = 1450;
    localparam int DRAIN_LIMIT  = 4000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         rx_byte;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         value_kind;
    logic signed [15:0] value;

    int mismatches;
    int readings_due;
    int bytes_taken;
    int readings_checked;

    int send_idle_pct;
    int recv_idle_pct;
    int bytes_sent;
    bit hold_request;
    bit hold_served;

    logic [7:0] frame_q [$];

    eeg_headset_packet_parser_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value_kind (value_kind),
        .value      (value)
    );

    eegpp_reading_checker reading_check
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .value_kind       (value_kind),
        .value            (value),
        .mismatches       (mismatches),
        .readings_due     (readings_due),
        .bytes_taken      (bytes_taken),
        .readings_checked (readings_checked)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Overall time limit
    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Result side: random stalls, or one long hold when asked for
    initial
    begin
        int hold_left;
        hold_left   = 0;
        hold_served = 1'b0;
        out_stall   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
                if (hold_left == 0)
                    hold_served = 1'b1;
            end
            else if (hold_request && !hold_served)
            begin
                hold_left = HOLD_CYCLES - 1;
                out_stall = 1'b1;
            end
            else
                out_stall = ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // One byte transfer; entered and left at a falling edge
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte  = b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_queued();
        foreach (frame_q[i])
            push_byte(frame_q[i]);
        frame_q.delete();
    endtask

    function automatic logic [7:0] pick_value();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Append one row, well-formed or otherwise, to the frame
    task automatic queue_random_row();
        int pick;
        int n;
        pick = $urandom_range(0, 10);
        case (pick)
            0, 1:
                frame_q.push_back(EXT_BYTE);
            2:
            begin
                frame_q.push_back(QUALITY_CODE);
                frame_q.push_back(pick_value());
            end
            3:
            begin
                frame_q.push_back(ATTENTION_CODE);
                frame_q.push_back(pick_value());
            end
            4:
            begin
                frame_q.push_back(MEDITATION_CODE);
                frame_q.push_back(pick_value());
            end
            5, 6, 7:
            begin
                // raw sample, mostly two bytes, sometimes short or long
                n = $urandom_range(0, 7);
                n = (n == 0) ? 0 : (n == 1) ? 1 : (n == 2) ? $urandom_range(3, 5) : 2;
                frame_q.push_back(RAW_CODE);
                frame_q.push_back(8'(n));
                repeat (n)
                    frame_q.push_back(pick_value());
            end
            8:
            begin
                frame_q.push_back(8'($urandom_range(0, 127)));
                frame_q.push_back(pick_value());
            end
            default:
            begin
                n = $urandom_range(0, 4);
                frame_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
                frame_q.push_back(8'(n));
                repeat (n)
                    frame_q.push_back(pick_value());
            end
        endcase
    endtask

    // Sync pair, length, rows trimmed to the length, then a checksum byte
    task automatic queue_frame(input int min_len, input int max_len);
        int len;
        int start;
        len = $urandom_range(min_len, max_len);
        frame_q.push_back(SYNC_BYTE);
        frame_q.push_back(SYNC_BYTE);
        frame_q.push_back(8'(len));
        start = frame_q.size();
        while (frame_q.size() - start < len)
            queue_random_row();
        while (frame_q.size() - start > len)
            frame_q.delete(frame_q.size() - 1);
        frame_q.push_back(($urandom_range(0, 5) == 0) ? SYNC_BYTE : pick_value());
    endtask

    // Line noise and broken headers
    task automatic queue_noise();
        case ($urandom_range(0, 3))
            0:
                repeat ($urandom_range(1, 6))
                    frame_q.push_back(8'($urandom_range(0, 255)));
            1:
            begin
                frame_q.push_back(SYNC_BYTE);
                frame_q.push_back(8'($urandom_range(0, 8'hA9)));
            end
            2:
            begin
                frame_q.push_back(SYNC_BYTE);
                frame_q.push_back(SYNC_BYTE);
                frame_q.push_back(8'($urandom_range(8'hAA, 8'hFF)));
            end
            default:
            begin
                frame_q.push_back(SYNC_BYTE);
                frame_q.push_back(SYNC_BYTE);
                frame_q.push_back(8'h00);
            end
        endcase
    endtask

    task automatic run_traffic(input int n_bytes);
        int goal;
        goal = bytes_sent + n_bytes;
        while (bytes_sent < goal)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                if ($urandom_range(0, 39) == 0)
                    queue_frame(21, 169);
                else
                    queue_frame(1, 20);
            end
            else
                queue_noise();
            send_queued();
        end
    endtask

    // Sender holds off until every reading has come out
    task automatic wait_for_readings();
        in_valid = 1'b0;
        while (readings_due != 0)
            @(negedge clk);
    endtask

    // Stimulus and verdict
    initial
    begin
        int waited;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        rx_byte       = 8'h00;
        hold_request  = 1'b0;
        bytes_sent    = 0;
        send_idle_pct = 15;
        recv_idle_pct = 83;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: broken headers, then a frame holding each row form
        frame_q = '{
            SYNC_BYTE, 8'h11,                            // second sync fails
            SYNC_BYTE, SYNC_BYTE, SYNC_BYTE,             // length too large
            SYNC_BYTE, SYNC_BYTE, 8'h00,                 // empty payload
            SYNC_BYTE, SYNC_BYTE, 8'd23,
            EXT_BYTE, QUALITY_CODE, 8'h00,
            MEDITATION_CODE, 8'h7F,
            RAW_CODE, 8'd2, 8'h80, 8'h00,                // most negative sample
            RAW_CODE, 8'd3, 8'h7F, 8'hFF, 8'h31,         // most positive, extra skipped
            8'h83, 8'd0,                                 // other code, no values
            RAW_CODE, 8'd1, 8'h12,                       // raw row too short
            RAW_CODE, 8'd4, 8'h12, 8'h34,                // row runs past payload end
            SYNC_BYTE,                                   // checksum doubles as sync
            SYNC_BYTE, 8'd2, ATTENTION_CODE, 8'hFF,
            8'h5A
        };
        send_queued();

        run_traffic(440);
        wait_for_readings();

        send_idle_pct = 83;
        recv_idle_pct = 15;
        run_traffic(440);
        wait_for_readings();

        // Long output hold while bytes keep coming, so the input backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        while (!hold_served)
        begin
            queue_frame(4, 20);
            send_queued();
        end
        wait_for_readings();

        // No idling on either side, one frame at the longest length
        queue_frame(169, 169);
        send_queued();
        if (bytes_sent < TOTAL_BYTES)
            run_traffic(TOTAL_BYTES - bytes_sent);

        in_valid = 1'b0;
        waited = 0;
        while (readings_due != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (8) @(negedge clk);

        $display("Covered %0d bytes and %0d readings under three stall mixes and a long hold.",
                 bytes_taken, readings_checked);
        if (mismatches == 0 && readings_due == 0)
            $display("Regression PASS");
        else
        begin
            if (readings_due != 0)
                $display("%0t ns: %0d expected readings never came out", $time, readings_due);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
